@@ src/rsbp_pkg.sv @@
// Shared types and constants for the road scroll background pixel generator.
package rsbp_pkg;

    typedef enum logic [1:0] {
        CMD_PIXEL     = 2'd0,
        CMD_LOAD_ROM  = 2'd1,
        CMD_LOAD_PROM = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_HSCROLL = 2'd0,
        REG_VSCROLL = 2'd1,
        REG_FLIP    = 2'd2,
        REG_BG_OFF  = 2'd3
    } t_reg;

    localparam int ROM_DEPTH       = 65536;
    localparam int PROM_HALF_DEPTH = 256;
    localparam int CFG_ADDR_W      = 4;

    localparam logic [8:0]  PEN_OFFSET = 9'h130;
    // 0xff01 taken modulo 2^14
    localparam logic [13:0] CURVE_BIAS = 14'h3f01;

endpackage

@@ src/rsbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rsbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/road_scroll_background_pixel.sv @@
// Top level: five-stage background pixel pipeline with APB register port.
// A pixel transaction passes the stage 1 to 4 registers and the output register before it shows on o_valid.
// Throughput: one transaction per cycle unless stalled; loads and pixels share the pipeline in order.
// The four stages that read graphics ROM copies and tile PROM halves set the depth.
// When the output is stalled the whole pipeline holds and o_stall is raised.
// Synchronous reset clears the configuration registers and valid bits; ROM and PROM
// contents are kept.
module road_scroll_background_pixel (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // pixel / load channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_command,
    input  logic [7:0]                         i_row,
    input  logic [7:0]                         i_column,
    input  logic [15:0]                        i_load_address,
    input  logic [7:0]                         i_load_byte,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [8:0]                         o_pen,
    output logic                               o_over_sprites,
    output logic [7:0]                         o_out_row,
    output logic [7:0]                         o_out_column,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rsbp_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    import rsbp_pkg::*;

    // configuration
    logic [13:0] r_hscroll;
    logic [7:0]  r_vscroll;
    logic        r_flip;
    logic        r_bg_off;
    logic        cfg_wr;
    t_reg        cfg_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_reg = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hscroll <= '0;
            r_vscroll <= '0;
            r_flip    <= 1'b0;
            r_bg_off  <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_reg)
                REG_HSCROLL: r_hscroll <= pwdata[13:0];
                REG_VSCROLL: r_vscroll <= pwdata[7:0];
                REG_FLIP:    r_flip    <= pwdata[0];
                REG_BG_OFF:  r_bg_off  <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (cfg_reg)
            REG_HSCROLL: prdata = {18'd0, r_hscroll};
            REG_VSCROLL: prdata = {24'd0, r_vscroll};
            REG_FLIP:    prdata = {31'd0, r_flip};
            REG_BG_OFF:  prdata = {31'd0, r_bg_off};
            default:     prdata = '0;
        endcase
    end

    // pipeline control
    logic en;
    logic acc;
    logic r_out_valid;

    assign en      = !(r_out_valid && i_stall);
    assign acc     = i_valid && en;
    assign o_stall = !en;

    // stage 0: row sum and curve address
    t_cmd        cmd0;
    logic        pix0;
    logic        lrom0;
    logic        lprom0;
    logic [8:0]  sv0;
    logic [7:0]  col_sel0;
    logic [15:0] curve_addr0;

    assign cmd0        = t_cmd'(i_command);
    assign pix0        = acc && (cmd0 == CMD_PIXEL);
    assign lrom0       = acc && (cmd0 == CMD_LOAD_ROM);
    assign lprom0      = acc && (cmd0 == CMD_LOAD_PROM);
    assign sv0         = {1'b0, r_vscroll} + {1'b0, i_row};
    assign col_sel0    = i_column[7] ? ~i_column : i_column;
    assign curve_addr0 = {2'b00, sv0[7:1], 7'd0} + {8'd0, col_sel0};

    logic [7:0] rom_a_q;

    rsbp_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom_curve (
        .i_clk   (i_clk),
        .i_we    (lrom0),
        .i_waddr (i_load_address),
        .i_wdata (i_load_byte),
        .i_re    (en),
        .i_raddr (curve_addr0),
        .o_rdata (rom_a_q)
    );

    // stage 1 registers
    logic        r_s1_pix, r_s1_lrom, r_s1_lprom;
    logic [7:0]  r_s1_row, r_s1_col;
    logic [8:0]  r_s1_sv;
    logic [15:0] r_s1_addr;
    logic [7:0]  r_s1_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_pix   <= 1'b0;
            r_s1_lrom  <= 1'b0;
            r_s1_lprom <= 1'b0;
        end else if (en) begin
            r_s1_pix   <= pix0;
            r_s1_lrom  <= lrom0;
            r_s1_lprom <= lprom0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_row  <= i_row;
            r_s1_col  <= i_column;
            r_s1_sv   <= sv0;
            r_s1_addr <= i_load_address;
            r_s1_byte <= i_load_byte;
        end
    end

    // stage 1: scrolled and curved column position
    logic [13:0] curve1;
    logic [13:0] pos1;
    logic        prom_lo_we, prom_hi_we;
    logic [7:0]  prom_lo_q, prom_hi_q;

    always_comb begin
        if (r_s1_sv[8]) begin
            curve1 = '0;
        end else if (r_s1_col[7]) begin
            curve1 = {6'd0, ~rom_a_q};
        end else begin
            curve1 = {6'd0, rom_a_q} + CURVE_BIAS;
        end
    end

    assign pos1       = r_hscroll + {6'd0, r_s1_col} + curve1;
    assign prom_lo_we = en && r_s1_lprom && !r_s1_addr[8];
    assign prom_hi_we = en && r_s1_lprom && r_s1_addr[8];

    rsbp_ram #(.WIDTH(8), .DEPTH(PROM_HALF_DEPTH)) u_prom_lo (
        .i_clk   (i_clk),
        .i_we    (prom_lo_we),
        .i_waddr (r_s1_addr[7:0]),
        .i_wdata (r_s1_byte),
        .i_re    (en),
        .i_raddr (pos1[13:6]),
        .o_rdata (prom_lo_q)
    );

    rsbp_ram #(.WIDTH(8), .DEPTH(PROM_HALF_DEPTH)) u_prom_hi (
        .i_clk   (i_clk),
        .i_we    (prom_hi_we),
        .i_waddr (r_s1_addr[7:0]),
        .i_wdata (r_s1_byte),
        .i_re    (en),
        .i_raddr (pos1[13:6]),
        .o_rdata (prom_hi_q)
    );

    // stage 2 registers
    logic        r_s2_pix, r_s2_lrom;
    logic [7:0]  r_s2_row, r_s2_col;
    logic [8:0]  r_s2_sv;
    logic [13:0] r_s2_pos;
    logic [15:0] r_s2_addr;
    logic [7:0]  r_s2_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_pix  <= 1'b0;
            r_s2_lrom <= 1'b0;
        end else if (en) begin
            r_s2_pix  <= r_s1_pix;
            r_s2_lrom <= r_s1_lrom;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_row  <= r_s1_row;
            r_s2_col  <= r_s1_col;
            r_s2_sv   <= r_s1_sv;
            r_s2_pos  <= pos1;
            r_s2_addr <= r_s1_addr;
            r_s2_byte <= r_s1_byte;
        end
    end

    // stage 2: tile entry and tile byte address
    logic [11:0] tile2;
    logic [15:0] tile_addr2;
    logic        rom_b_we;
    logic [7:0]  rom_b_q;

    assign tile2      = {prom_lo_q, 4'd0} + {4'd0, prom_hi_q};
    // fields do not overlap, so the sums collapse into a concatenation
    assign tile_addr2 = {2'b01, r_s2_sv[8], tile2[4:0], r_s2_sv[7:3], r_s2_pos[5:3]};
    assign rom_b_we   = en && r_s2_lrom;

    rsbp_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom_tile (
        .i_clk   (i_clk),
        .i_we    (rom_b_we),
        .i_waddr (r_s2_addr),
        .i_wdata (r_s2_byte),
        .i_re    (en),
        .i_raddr (tile_addr2),
        .o_rdata (rom_b_q)
    );

    // stage 3 registers
    logic        r_s3_pix, r_s3_lrom;
    logic [7:0]  r_s3_row, r_s3_col;
    logic        r_s3_half;
    logic [2:0]  r_s3_sv_lo;
    logic [2:0]  r_s3_pos_lo;
    logic        r_s3_pat_half;
    logic [2:0]  r_s3_color;
    logic [15:0] r_s3_addr;
    logic [7:0]  r_s3_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_pix  <= 1'b0;
            r_s3_lrom <= 1'b0;
        end else if (en) begin
            r_s3_pix  <= r_s2_pix;
            r_s3_lrom <= r_s2_lrom;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_row      <= r_s2_row;
            r_s3_col      <= r_s2_col;
            r_s3_half     <= r_s2_sv[8];
            r_s3_sv_lo    <= r_s2_sv[2:0];
            r_s3_pos_lo   <= r_s2_pos[2:0];
            r_s3_pat_half <= tile2[4];
            r_s3_color    <= tile2[7:5];
            r_s3_addr     <= r_s2_addr;
            r_s3_byte     <= r_s2_byte;
        end
    end

    // stage 3: pattern byte address
    logic [15:0] pat_addr3;
    logic        rom_c_we;
    logic [7:0]  rom_c_q;

    assign pat_addr3 = {1'b1, r_s3_pat_half, r_s3_half, rom_b_q, r_s3_sv_lo,
                        r_s3_pos_lo[2:1]};
    assign rom_c_we  = en && r_s3_lrom;

    rsbp_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom_pattern (
        .i_clk   (i_clk),
        .i_we    (rom_c_we),
        .i_waddr (r_s3_addr),
        .i_wdata (r_s3_byte),
        .i_re    (en),
        .i_raddr (pat_addr3),
        .o_rdata (rom_c_q)
    );

    // stage 4 registers
    logic       r_s4_pix;
    logic [7:0] r_s4_row, r_s4_col;
    logic       r_s4_half;
    logic       r_s4_pos0;
    logic [2:0] r_s4_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_pix <= 1'b0;
        end else if (en) begin
            r_s4_pix <= r_s3_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_row   <= r_s3_row;
            r_s4_col   <= r_s3_col;
            r_s4_half  <= r_s3_half;
            r_s4_pos0  <= r_s3_pos_lo[0];
            r_s4_color <= r_s3_color;
        end
    end

    // stage 4: nibble select, pen and flip
    logic [3:0] nib4;
    logic [8:0] pen4;
    logic       pri4;

    assign nib4 = r_s4_pos0 ? rom_c_q[7:4] : rom_c_q[3:0];
    assign pen4 = PEN_OFFSET + {r_s4_half, 7'd0} + {2'd0, r_s4_color, 4'd0} + {5'd0, nib4};
    assign pri4 = r_s4_half && (nib4[3:2] == 2'b11);

    logic [8:0] r_pen;
    logic       r_pri;
    logic [7:0] r_out_row, r_out_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s4_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pen     <= r_bg_off ? '0 : pen4;
            r_pri     <= r_bg_off ? 1'b0 : pri4;
            r_out_row <= r_flip ? ~r_s4_row : r_s4_row;
            r_out_col <= r_flip ? ~r_s4_col : r_s4_col;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pen          = r_pen;
    assign o_over_sprites = r_pri;
    assign o_out_row      = r_out_row;
    assign o_out_column   = r_out_col;

    // a transaction in the last stage reaches the output when the pipe advances
    a_out_follows_s4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> (r_out_valid == $past(r_s4_pix)))
        else $error("output valid does not follow stage 4");

    // load transactions never produce a result slot
    a_load_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (lrom0 || lprom0)) |=> !r_s1_pix)
        else $error("load transaction entered as pixel");

    // priority only for nibbles with both top bits set, which land in the pen low bits
    a_pri_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_over_sprites) |-> (o_pen[3:2] == 2'b11))
        else $error("priority flag with wrong nibble");

    // a held pipeline writes no memory
    a_no_write_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> !(lrom0 || prom_lo_we || prom_hi_we || rom_b_we || rom_c_we))
        else $error("memory written while pipeline held");

endmodule
